// ===== rtl/nsmcw_pkg.sv =====
// Shared types and constants for the nixie scan multiplexer.
package nsmcw_pkg;

    localparam int MAX_TUBES  = 8;
    localparam int TUBE_W     = 3;
    localparam int DIGIT_W    = 4;
    localparam int MASK_W     = 8;
    localparam int KIND_W     = 3;
    localparam int TARGET_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [3:0] FADE_SCANS       = 4'd12;
    localparam logic [3:0] FADE_SCANS_TUBE0 = 4'd5;
    localparam logic [3:0] WIPE_LAST_STEP   = 4'd7;
    localparam logic [7:0] WIPE_RATE_RESET  = 8'd4;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SCAN   = 3'd0,
        KIND_SLOW   = 3'd1,
        KIND_DIGIT  = 3'd2,
        KIND_WIPE   = 3'd3,
        KIND_ALT    = 3'd4,
        KIND_EBLANK = 3'd5
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CROSSFADE  = 3'd0,
        CFG_ALL_BLANK  = 3'd1,
        CFG_TUBE_BLANK = 3'd2,
        CFG_WIPE_RATE  = 3'd3,
        CFG_WIPE_STYLE = 3'd4
    } cfg_idx_t;

    // Wipe goals (also the wipe target codes)
    localparam logic [1:0] GOAL_ON  = 2'd0;
    localparam logic [1:0] GOAL_OFF = 2'd1;
    localparam logic [1:0] GOAL_ALT = 2'd2;

    // Wipe styles
    localparam logic [1:0] STYLE_FROM_HIGH = 2'd0;
    localparam logic [1:0] STYLE_FROM_LOW  = 2'd1;
    localparam logic [1:0] STYLE_TOGGLE    = 2'd2;

    // Wipe direction
    localparam logic DIR_FROM_HIGH = 1'b0;
    localparam logic DIR_FROM_LOW  = 1'b1;

    typedef struct packed {
        logic              crossfade_on;
        logic              all_blank;
        logic [MASK_W-1:0] tube_blank_mask;
        logic [7:0]        wipe_rate;
        logic [1:0]        wipe_style;
    } cfg_t;

    // Decoded request, each flag qualified by the request being processed
    typedef struct packed {
        logic                is_scan;
        logic                is_slow;
        logic                is_digit;
        logic                is_wipe;
        logic                is_alt;
        logic                is_eblank;
        logic [TUBE_W-1:0]   tube;
        logic [DIGIT_W-1:0]  digit;
        logic [TARGET_W-1:0] target;
        logic [MASK_W-1:0]   mask;
    } op_t;

    typedef struct packed {
        logic [MASK_W-1:0] alt_mask;
        logic [MASK_W-1:0] effect_blank_mask;
        logic              wipe_running;
    } masks_t;

    typedef struct packed {
        logic [MASK_W-1:0] anode;
        logic [7:0]        cath_first;
        logic [7:0]        cath_second;
    } scan_res_t;

endpackage

// ===== rtl/nsmcw_if.sv =====
// Handshake channel interfaces: request, result and configuration write.
interface nsmcw_item_if;
    logic                          valid;
    logic                          ready;
    logic [nsmcw_pkg::KIND_W-1:0]   kind;
    logic [nsmcw_pkg::TUBE_W-1:0]   tube_index;
    logic [nsmcw_pkg::DIGIT_W-1:0]  digit_value;
    logic [nsmcw_pkg::TARGET_W-1:0] wipe_target;
    logic [nsmcw_pkg::MASK_W-1:0]   mask_value;

    modport source (output valid, kind, tube_index, digit_value, wipe_target, mask_value,
                    input ready);
    modport sink (input valid, kind, tube_index, digit_value, wipe_target, mask_value,
                  output ready);
endinterface

interface nsmcw_result_if;
    logic                        valid;
    logic                        ready;
    logic [nsmcw_pkg::MASK_W-1:0] anode_bits;
    logic [7:0]                  cathode_first_byte;
    logic [7:0]                  cathode_second_byte;
    logic                        wipe_busy;

    modport source (output valid, anode_bits, cathode_first_byte, cathode_second_byte,
                    wipe_busy, input ready);
    modport sink (input valid, anode_bits, cathode_first_byte, cathode_second_byte,
                  wipe_busy, output ready);
endinterface

interface nsmcw_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [nsmcw_pkg::CFG_IDX_W-1:0]  index;
    logic [nsmcw_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/nsmcw_wipe.sv =====
// Wipe effect engine: alternate and effect-blank masks and wipe sequencing.
module nsmcw_wipe (
    input  logic              clk,
    input  logic              rst_n,
    input  nsmcw_pkg::cfg_t   cfg,
    input  nsmcw_pkg::op_t    op,
    output nsmcw_pkg::masks_t masks
);
    import nsmcw_pkg::*;

    logic [MASK_W-1:0] alt_reg, alt_next;
    logic [MASK_W-1:0] eblank_reg, eblank_next;
    logic              running_reg, running_next;
    logic [3:0]        step_reg, step_next;
    logic [7:0]        rate_cnt_reg, rate_cnt_next;
    logic              dir_reg, dir_next;
    logic [1:0]        goal_reg, goal_next;
    logic [1:0]        origin_reg, origin_next;

    logic              dir_chosen;
    logic [7:0]        rate_dec;
    logic [15:0]       low_fill;
    logic [MASK_W-1:0] low_mask;
    logic [MASK_W-1:0] high_mask;
    logic [MASK_W-1:0] edge_mask;

    // Build the edge mask of step_reg bits
    always_comb
    begin
        low_fill = ~(16'hFFFF << step_reg);
        low_mask = low_fill[MASK_W-1:0];
        for (int i = 0; i < MASK_W; i++)
        begin
            high_mask[i] = low_mask[MASK_W-1-i];
        end
        edge_mask = (dir_reg == DIR_FROM_LOW) ? low_mask : high_mask;
    end

    assign dir_chosen = (cfg.wipe_style == STYLE_TOGGLE) ? ~dir_reg
                                                         : (cfg.wipe_style == STYLE_FROM_LOW);
    assign rate_dec   = rate_cnt_reg - 8'd1;

    // Advance wipe, start wipe, take mask writes
    always_comb
    begin
        alt_next      = alt_reg;
        eblank_next   = eblank_reg;
        running_next  = running_reg;
        step_next     = step_reg;
        rate_cnt_next = rate_cnt_reg;
        dir_next      = dir_reg;
        goal_next     = goal_reg;
        origin_next   = origin_reg;

        if (op.is_slow && running_reg && !cfg.all_blank)
        begin
            rate_cnt_next = rate_dec;
            if (rate_dec == 8'd0)
            begin
                case (goal_reg)
                    GOAL_ON:
                    begin
                        if (origin_reg == GOAL_OFF)
                        begin
                            eblank_next = ~edge_mask;
                        end
                        else
                        begin
                            alt_next = ~edge_mask;
                        end
                    end
                    GOAL_OFF: eblank_next = edge_mask;
                    GOAL_ALT: alt_next = edge_mask;
                    default: ;
                endcase
                rate_cnt_next = cfg.wipe_rate;
                if (step_reg > WIPE_LAST_STEP)
                begin
                    running_next = 1'b0;
                    if (goal_reg == GOAL_ON)
                    begin
                        dir_next = dir_chosen;
                    end
                end
                step_next = step_reg + 4'd1;
            end
        end

        if (op.is_wipe && !cfg.all_blank)
        begin
            rate_cnt_next = cfg.wipe_rate;
            step_next     = 4'd1;
            running_next  = 1'b1;
            dir_next      = dir_chosen;
            if (op.target == GOAL_ON)
            begin
                origin_next = goal_reg;
                goal_next   = GOAL_ON;
            end
            else
            begin
                goal_next = op.target;
            end
        end

        if (op.is_alt && !cfg.all_blank)
        begin
            alt_next = op.mask;
        end

        if (op.is_eblank && !cfg.all_blank)
        begin
            eblank_next = op.mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_reg      <= '0;
            eblank_reg   <= '0;
            running_reg  <= 1'b0;
            step_reg     <= 4'd1;
            rate_cnt_reg <= WIPE_RATE_RESET;
            dir_reg      <= DIR_FROM_HIGH;
            goal_reg     <= GOAL_ON;
            origin_reg   <= GOAL_ON;
        end
        else
        begin
            alt_reg      <= alt_next;
            eblank_reg   <= eblank_next;
            running_reg  <= running_next;
            step_reg     <= step_next;
            rate_cnt_reg <= rate_cnt_next;
            dir_reg      <= dir_next;
            goal_reg     <= goal_next;
            origin_reg   <= origin_next;
        end
    end

    assign masks.alt_mask          = alt_reg;
    assign masks.effect_blank_mask = eblank_reg;
    assign masks.wipe_running      = running_reg;

    // A running wipe never goes past its last step
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (step_reg != 4'd0 && step_reg <= WIPE_LAST_STEP + 4'd1))
        else $error("wipe step out of range while running");

endmodule

// ===== rtl/nsmcw_scan.sv =====
// Tube scanner: per-tube digit lanes, cross-fade and anode/cathode bytes.
module nsmcw_scan #(
    parameter int NUM_TUBES  = 7,
    parameter int NUM_DIGITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nsmcw_pkg::cfg_t      cfg,
    input  nsmcw_pkg::op_t       op,
    input  nsmcw_pkg::masks_t    masks,
    output nsmcw_pkg::scan_res_t res
);
    import nsmcw_pkg::*;

    localparam int CYC_W = $clog2(NUM_DIGITS);

    logic [TUBE_W-1:0]  ptr_reg, ptr_next;
    logic [TUBE_W:0]    ptr_inc;
    logic [TUBE_W-1:0]  scan_p;

    logic [DIGIT_W-1:0] req_lane    [MAX_TUBES];
    logic [DIGIT_W-1:0] shown_lane  [MAX_TUBES];
    logic [DIGIT_W-1:0] prev_lane   [MAX_TUBES];
    logic [3:0]         fade_lane   [MAX_TUBES];
    logic [CYC_W-1:0]   cyc_lane    [MAX_TUBES];

    logic               alt;
    logic               load_fade;
    logic               light_prev;
    logic               lit;
    logic [DIGIT_W-1:0] new_shown;
    logic [DIGIT_W-1:0] new_prev;
    logic [3:0]         fade_loaded;
    logic [3:0]         new_fade;
    logic [15:0]        cath_on;
    logic [15:0]        cath_n;

    // Step the pointer, wrap at the tube count
    assign ptr_inc  = {1'b0, ptr_reg} + 4'd1;
    assign scan_p   = ({1'b0, ptr_inc[TUBE_W-1:0]} >= 4'(NUM_TUBES)) ? '0
                                                                     : ptr_inc[TUBE_W-1:0];
    assign ptr_next = op.is_scan ? scan_p : ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    // Work out the scanned tube's new digits and drive bytes
    always_comb
    begin
        alt         = masks.alt_mask[scan_p];
        load_fade   = cfg.crossfade_on && (shown_lane[scan_p] != req_lane[scan_p]);
        new_prev    = load_fade ? shown_lane[scan_p] : prev_lane[scan_p];
        fade_loaded = load_fade ? ((scan_p == '0) ? FADE_SCANS_TUBE0 : FADE_SCANS)
                                : fade_lane[scan_p];
        new_shown   = alt ? DIGIT_W'(cyc_lane[scan_p]) : req_lane[scan_p];
        light_prev  = cfg.crossfade_on && (fade_loaded != 4'd0);
        new_fade    = light_prev ? (fade_loaded - 4'd1) : fade_loaded;
        cath_on     = (16'd1 << new_shown) | (light_prev ? (16'd1 << new_prev) : 16'd0);
        cath_n      = ~cath_on;
        lit         = !cfg.all_blank &&
                      ((!cfg.tube_blank_mask[scan_p] && !masks.effect_blank_mask[scan_p])
                       || alt);
        res.anode       = lit ? (MASK_W'(1) << scan_p) : '0;
        res.cath_first  = cath_n[15:8];
        res.cath_second = cath_n[7:0];
    end

    // One lane of digit state per tube that is fitted
    for (genvar t = 0; t < MAX_TUBES; t++)
    begin : g_lane
        if (t < NUM_TUBES)
        begin : g_used
            localparam logic [TUBE_W-1:0] LANE = TUBE_W'(t);

            logic [DIGIT_W-1:0] req_reg;
            logic [DIGIT_W-1:0] shown_reg;
            logic [DIGIT_W-1:0] prev_reg;
            logic [3:0]         fade_reg;
            logic [CYC_W-1:0]   cyc_reg;
            logic [CYC_W:0]     cyc_inc;
            logic               scan_hit;
            logic               write_hit;

            assign scan_hit  = op.is_scan && (scan_p == LANE);
            assign write_hit = op.is_digit && (op.tube == LANE);
            assign cyc_inc   = {1'b0, cyc_reg} + (CYC_W+1)'(1);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    req_reg   <= '0;
                    shown_reg <= '0;
                    prev_reg  <= '0;
                    fade_reg  <= '0;
                    cyc_reg   <= '0;
                end
                else
                begin
                    if (write_hit)
                    begin
                        req_reg <= op.digit;
                    end
                    if (scan_hit)
                    begin
                        shown_reg <= new_shown;
                        prev_reg  <= new_prev;
                        fade_reg  <= new_fade;
                    end
                    // Advance the alternate digit, wrap at the digit count
                    if (op.is_slow)
                    begin
                        cyc_reg <= (cyc_inc >= (CYC_W+1)'(NUM_DIGITS)) ? '0
                                                                       : cyc_inc[CYC_W-1:0];
                    end
                end
            end

            assign req_lane[t]   = req_reg;
            assign shown_lane[t] = shown_reg;
            assign prev_lane[t]  = prev_reg;
            assign fade_lane[t]  = fade_reg;
            assign cyc_lane[t]   = cyc_reg;
        end
        else
        begin : g_absent
            assign req_lane[t]   = '0;
            assign shown_lane[t] = '0;
            assign prev_lane[t]  = '0;
            assign fade_lane[t]  = '0;
            assign cyc_lane[t]   = '0;
        end
    end

    // The pointer only ever names a fitted tube
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, ptr_reg} < 4'(NUM_TUBES))
        else $error("scan pointer beyond fitted tubes");

endmodule

// ===== rtl/nixie_scan_mux_crossfade_wipe.sv =====
// Top level: request register, configuration registers, result register.
//
//  channel  role    carries
//  -------  ------  ---------------------------------------------------------
//  item     sink    kind, tube_index, digit_value, wipe_target, mask_value
//  result   source  anode_bits, cathode_first_byte, cathode_second_byte, wipe_busy
//  cfg      sink    index, data (always ready)
//
//  A request is registered on accept and processed from there by the scan lanes
//  and the wipe engine; a scan tick's bytes are captured in the result register.
//  One request per cycle is sustained; a scan tick waits in the request
//  register only while the result register is full and not being taken.
//  Reset clears all digit lanes, masks and wipe state; no clearing pass.
module nixie_scan_mux_crossfade_wipe #(
    parameter int NUM_TUBES  = 7,
    parameter int NUM_DIGITS = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    nsmcw_cfg_if.sink      cfg,
    nsmcw_item_if.sink     item,
    nsmcw_result_if.source result
);
    import nsmcw_pkg::*;

    cfg_t                cfg_reg, cfg_next;

    logic                item_valid_reg, item_valid_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [TUBE_W-1:0]   tube_reg;
    logic [DIGIT_W-1:0]  digit_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [MASK_W-1:0]   mask_reg;

    logic                out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]   anode_reg;
    logic [7:0]          cath_first_reg;
    logic [7:0]          cath_second_reg;
    logic                busy_reg;

    logic                item_take;
    logic                item_is_scan;
    logic                out_free;
    logic                proc;
    logic                proc_scan;
    op_t                 op;
    masks_t              masks;
    scan_res_t           scan_res;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CROSSFADE:  cfg_next.crossfade_on    = cfg.data[0];
                CFG_ALL_BLANK:  cfg_next.all_blank       = cfg.data[0];
                CFG_TUBE_BLANK: cfg_next.tube_blank_mask = cfg.data;
                CFG_WIPE_RATE:  cfg_next.wipe_rate       = cfg.data;
                CFG_WIPE_STYLE: cfg_next.wipe_style      = cfg.data[1:0];
                default: ;
            endcase
        end
    end

    // Process a held request unless it is a scan blocked by a full result slot
    assign item_is_scan = (kind_reg == KIND_SCAN);
    assign out_free     = !out_valid_reg || result.ready;
    assign proc         = item_valid_reg && (!item_is_scan || out_free);
    assign proc_scan    = proc && item_is_scan;
    assign item.ready   = !item_valid_reg || proc;
    assign item_take    = item.valid && item.ready;

    assign item_valid_next = item_take ? 1'b1 : (proc ? 1'b0 : item_valid_reg);
    assign out_valid_next  = proc_scan ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    // Decode the held request
    always_comb
    begin
        op        = '0;
        op.tube   = tube_reg;
        op.digit  = digit_reg;
        op.target = target_reg;
        op.mask   = mask_reg;
        unique case (kind_reg)
            KIND_SCAN:   op.is_scan   = proc;
            KIND_SLOW:   op.is_slow   = proc;
            KIND_DIGIT:  op.is_digit  = proc;
            KIND_WIPE:   op.is_wipe   = proc;
            KIND_ALT:    op.is_alt    = proc;
            KIND_EBLANK: op.is_eblank = proc;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crossfade_on    <= 1'b0;
            cfg_reg.all_blank       <= 1'b0;
            cfg_reg.tube_blank_mask <= '0;
            cfg_reg.wipe_rate       <= WIPE_RATE_RESET;
            cfg_reg.wipe_style      <= STYLE_FROM_HIGH;
            item_valid_reg          <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold the request payload
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            kind_reg   <= item.kind;
            tube_reg   <= item.tube_index;
            digit_reg  <= item.digit_value;
            target_reg <= item.wipe_target;
            mask_reg   <= item.mask_value;
        end
    end

    // Capture the scan result
    always_ff @(posedge clk)
    begin
        if (proc_scan)
        begin
            anode_reg       <= scan_res.anode;
            cath_first_reg  <= scan_res.cath_first;
            cath_second_reg <= scan_res.cath_second;
            busy_reg        <= masks.wipe_running;
        end
    end

    nsmcw_wipe u_wipe (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .op    (op),
        .masks (masks)
    );

    nsmcw_scan #(
        .NUM_TUBES  (NUM_TUBES),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .op    (op),
        .masks (masks),
        .res   (scan_res)
    );

    assign result.valid               = out_valid_reg;
    assign result.anode_bits          = anode_reg;
    assign result.cathode_first_byte  = cath_first_reg;
    assign result.cathode_second_byte = cath_second_reg;
    assign result.wipe_busy           = busy_reg;

    // A processed scan always shows up in the result register
    a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc_scan |=> out_valid_reg)
        else $error("scan tick processed without a result");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !proc_scan)
        else $error("pending result overwritten");

    // At most one anode is driven
    a_anode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0(anode_reg))
        else $error("more than one anode lit");

endmodule

// ===== tb/nixie_scan_mux_crossfade_wipe_test.sv =====
// Self-checking testbench for the nixie scan multiplexer with cross-fade and wipe effect.
module nixie_scan_mux_crossfade_wipe_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nsmcw_pkg::*;

    localparam int NUM_TUBES      = 7;
    localparam int NUM_DIGITS     = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 160;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // Codes the package leaves unnamed
    localparam logic [KIND_W-1:0]   KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0]   KIND_SPARE_7 = 3'd7;
    localparam logic [TARGET_W-1:0] GOAL_NONE    = 2'd3;
    localparam logic [1:0]          STYLE_SPARE  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [TUBE_W-1:0]   tube;
        logic [DIGIT_W-1:0]  digit;
        logic [TARGET_W-1:0] target;
        logic [MASK_W-1:0]   mask;
    } tube_req_t;

    typedef struct packed {
        logic [MASK_W-1:0] anode;
        logic [7:0]        cath_first;
        logic [7:0]        cath_second;
        logic              busy;
    } scan_out_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Testbench side of the three channels
    logic                  drv_valid  = 1'b0;
    tube_req_t             drv_req    = '0;
    logic                  sink_ready = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  req_taken  = 1'b0;
    logic                  cfg_taken  = 1'b0;

    tube_req_t request_q[$];
    scan_out_t scan_expect_q[$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_asked   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int fail_count   = 0;
    int idle_cycles  = 0;
    int queued_count = 0;

    // Mirrored settings
    logic       m_crossfade  = 1'b0;
    logic       m_blank_all  = 1'b0;
    logic [7:0] m_tube_blank = 8'h00;
    logic [7:0] m_rate       = WIPE_RATE_RESET;
    logic [1:0] m_style      = STYLE_FROM_HIGH;

    // Mirrored scanner and wipe state
    logic [2:0] scan_ptr              = 3'd0;
    logic [3:0] req_digit [MAX_TUBES]   = '{default: 4'd0};
    logic [3:0] shown_digit [MAX_TUBES] = '{default: 4'd0};
    logic [3:0] prev_digit [MAX_TUBES]  = '{default: 4'd0};
    logic [3:0] cyc_digit [MAX_TUBES]   = '{default: 4'd0};
    logic [3:0] fade_cnt [MAX_TUBES]    = '{default: 4'd0};
    logic [7:0] alt_mask    = 8'h00;
    logic [7:0] eblank_mask = 8'h00;
    logic       wipe_run    = 1'b0;
    logic [3:0] wipe_step   = 4'd1;
    logic [7:0] wipe_count  = WIPE_RATE_RESET;
    logic       wipe_dir    = DIR_FROM_HIGH;
    logic [1:0] wipe_goal   = GOAL_ON;
    logic [1:0] wipe_origin = GOAL_ON;

    nsmcw_cfg_if    cfg_ch ();
    nsmcw_item_if   item_ch ();
    nsmcw_result_if res_ch ();

    assign item_ch.valid       = drv_valid;
    assign item_ch.kind        = drv_req.kind;
    assign item_ch.tube_index  = drv_req.tube;
    assign item_ch.digit_value = drv_req.digit;
    assign item_ch.wipe_target = drv_req.target;
    assign item_ch.mask_value  = drv_req.mask;
    assign res_ch.ready        = sink_ready;
    assign cfg_ch.valid        = cfg_valid;
    assign cfg_ch.index        = cfg_index;
    assign cfg_ch.data         = cfg_data;

    nixie_scan_mux_crossfade_wipe #(
        .NUM_TUBES  (NUM_TUBES),
        .NUM_DIGITS (NUM_DIGITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (res_ch)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Pick the wipe direction for the current style
    function automatic logic next_wipe_dir(input logic dir);
        if (m_style == STYLE_TOGGLE)
            return ~dir;
        return (m_style == STYLE_FROM_LOW) ? DIR_FROM_LOW : DIR_FROM_HIGH;
    endfunction

    // Advance the mirrored state by one request; queue the scan output it causes
    task automatic predict_request(input tube_req_t rq);
        logic [2:0] p;
        logic       alt;
        logic [3:0] val;
        logic [4:0] c;
        logic [7:0] m;
        scan_out_t  res;
        case (kind_t'(rq.kind))
            KIND_SCAN:
            begin
                p = scan_ptr + 3'd1;
                if (p >= NUM_TUBES)
                    p = 3'd0;
                scan_ptr = p;
                alt = alt_mask[p];
                // Start a fade when the tube's digit changed
                if (m_crossfade && shown_digit[p] != req_digit[p])
                begin
                    prev_digit[p] = shown_digit[p];
                    fade_cnt[p] = (p == 3'd0) ? FADE_SCANS_TUBE0 : FADE_SCANS;
                end
                shown_digit[p] = alt ? cyc_digit[p] : req_digit[p];
                res.anode = (!m_blank_all && ((!m_tube_blank[p] && !eblank_mask[p]) || alt))
                            ? (8'h01 << p) : 8'h00;
                res.cath_first = 8'hFF;
                res.cath_second = 8'hFF;
                val = shown_digit[p];
                if (val[3])
                    res.cath_first[val[2:0]] = 1'b0;
                else
                    res.cath_second[val[2:0]] = 1'b0;
                // Light the old cathode too while the fade lasts
                if (m_crossfade && fade_cnt[p] != 4'd0)
                begin
                    val = prev_digit[p];
                    if (val[3])
                        res.cath_first[val[2:0]] = 1'b0;
                    else
                        res.cath_second[val[2:0]] = 1'b0;
                    fade_cnt[p] = fade_cnt[p] - 4'd1;
                end
                res.busy = wipe_run;
                scan_expect_q.push_back(res);
            end
            KIND_SLOW:
            begin
                if (wipe_run && !m_blank_all)
                begin
                    wipe_count = wipe_count - 8'd1;
                    if (wipe_count == 8'd0)
                    begin
                        // Grow the mask from the chosen edge
                        m = 8'h00;
                        for (int v = 0; v < 16; v++)
                            if (v < wipe_step)
                                m = m | ((wipe_dir == DIR_FROM_LOW) ? (8'h01 << v)
                                                                     : (8'h80 >> v));
                        case (wipe_goal)
                            GOAL_ON:
                            begin
                                if (wipe_origin == GOAL_OFF)
                                    eblank_mask = ~m;
                                else
                                    alt_mask = ~m;
                            end
                            GOAL_OFF: eblank_mask = m;
                            GOAL_ALT: alt_mask = m;
                            default: ;
                        endcase
                        wipe_count = m_rate;
                        if (wipe_step > WIPE_LAST_STEP)
                        begin
                            wipe_run = 1'b0;
                            if (wipe_goal == GOAL_ON)
                                wipe_dir = next_wipe_dir(wipe_dir);
                        end
                        wipe_step = wipe_step + 4'd1;
                    end
                end
                // Step every fitted tube's cycling digit
                for (int t = 0; t < NUM_TUBES; t++)
                begin
                    c = {1'b0, cyc_digit[t]} + 5'd1;
                    if (c >= NUM_DIGITS)
                        c = 5'd0;
                    cyc_digit[t] = c[3:0];
                end
            end
            KIND_DIGIT: req_digit[rq.tube] = rq.digit;
            KIND_WIPE:
            begin
                if (!m_blank_all)
                begin
                    wipe_count = m_rate;
                    wipe_step = 4'd1;
                    wipe_run = 1'b1;
                    wipe_dir = next_wipe_dir(wipe_dir);
                    if (rq.target == GOAL_ON)
                    begin
                        wipe_origin = wipe_goal;
                        wipe_goal = GOAL_ON;
                    end
                    else
                        wipe_goal = rq.target;
                end
            end
            KIND_ALT:
            begin
                if (!m_blank_all)
                    alt_mask = rq.mask;
            end
            KIND_EBLANK:
            begin
                if (!m_blank_all)
                    eblank_mask = rq.mask;
            end
            default: ;
        endcase
    endtask

    // Track accepted requests and register writes
    always @(posedge clk)
    begin
        req_taken <= drv_valid && item_ch.ready;
        cfg_taken <= cfg_valid && cfg_ch.ready;
        if (rst_n && drv_valid && item_ch.ready)
            predict_request(drv_req);
        if (rst_n && cfg_valid && cfg_ch.ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CROSSFADE:  m_crossfade = cfg_data[0];
                CFG_ALL_BLANK:  m_blank_all = cfg_data[0];
                CFG_TUBE_BLANK: m_tube_blank = cfg_data;
                CFG_WIPE_RATE:  m_rate = cfg_data;
                CFG_WIPE_STYLE: m_style = cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Check each scan output against the oldest expectation
    always @(posedge clk)
    begin
        scan_out_t want;
        if (rst_n && res_ch.valid && sink_ready)
        begin
            if (scan_expect_q.size() == 0)
            begin
                $error("unexpected scan result: anode_bits %h", res_ch.anode_bits);
                fail_count++;
            end
            else
            begin
                want = scan_expect_q.pop_front();
                if (res_ch.anode_bits !== want.anode)
                begin
                    $error("anode_bits: expected %h, got %h", want.anode, res_ch.anode_bits);
                    fail_count++;
                end
                if (res_ch.cathode_first_byte !== want.cath_first)
                begin
                    $error("cathode_first_byte: expected %h, got %h",
                           want.cath_first, res_ch.cathode_first_byte);
                    fail_count++;
                end
                if (res_ch.cathode_second_byte !== want.cath_second)
                begin
                    $error("cathode_second_byte: expected %h, got %h",
                           want.cath_second, res_ch.cathode_second_byte);
                    fail_count++;
                end
                if (res_ch.wipe_busy !== want.busy)
                begin
                    $error("wipe_busy: expected %b, got %b", want.busy, res_ch.wipe_busy);
                    fail_count++;
                end
            end
        end
    end

    // Feed pending requests, with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!drv_valid || req_taken))
        begin
            if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                drv_req <= request_q.pop_front();
                drv_valid <= 1'b1;
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // Drive result ready; hold it low for a long stretch when asked
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            sink_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            sink_ready <= 1'b0;
        end
        else
            sink_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((drv_valid && item_ch.ready) || (res_ch.valid && sink_ready) ||
            (cfg_valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("nixie_scan_mux_crossfade_wipe_test: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(negedge clk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic cf, input logic ab, input logic [7:0] tb,
                                 input logic [7:0] rate, input logic [1:0] style);
        write_reg(CFG_CROSSFADE, {7'd0, cf});
        write_reg(CFG_ALL_BLANK, {7'd0, ab});
        write_reg(CFG_TUBE_BLANK, tb);
        write_reg(CFG_WIPE_RATE, rate);
        write_reg(CFG_WIPE_STYLE, {6'd0, style});
    endtask

    // Wait until every request is in and every scan output is out, then let the pipe settle
    task automatic wait_idle();
        do @(posedge clk);
        while (request_q.size() != 0 || drv_valid || scan_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void queue_req(input tube_req_t rq);
        request_q.push_back(rq);
        queued_count++;
    endfunction

    function automatic void queue_fields(input logic [KIND_W-1:0] kind,
                                         input logic [TUBE_W-1:0] tube,
                                         input logic [DIGIT_W-1:0] digit,
                                         input logic [TARGET_W-1:0] target,
                                         input logic [MASK_W-1:0] mask);
        tube_req_t rq;
        rq.kind = kind;
        rq.tube = tube;
        rq.digit = digit;
        rq.target = target;
        rq.mask = mask;
        queue_req(rq);
    endfunction

    // Random request: mostly scans and slow ticks, every field filled with noise
    function automatic tube_req_t random_req();
        tube_req_t rq;
        int        roll;
        rq.tube = TUBE_W'($urandom_range(7));
        rq.digit = DIGIT_W'($urandom_range(15));
        rq.target = TARGET_W'($urandom_range(3));
        rq.mask = MASK_W'($urandom_range(255));
        roll = $urandom_range(99);
        if (roll < 40)
            rq.kind = KIND_SCAN;
        else if (roll < 62)
            rq.kind = KIND_SLOW;
        else if (roll < 77)
            rq.kind = KIND_DIGIT;
        else if (roll < 83)
            rq.kind = KIND_WIPE;
        else if (roll < 89)
            rq.kind = KIND_ALT;
        else if (roll < 95)
            rq.kind = KIND_EBLANK;
        else
            rq.kind = $urandom_range(1) ? KIND_SPARE_7 : KIND_SPARE_6;
        return rq;
    endfunction

    // Start a wipe with slow ticks and scans in between; enough to finish at rates 1 to 3
    task automatic queue_wipe_sweep();
        int        steps;
        tube_req_t rq;
        steps = (m_rate == 8'd0 || m_rate > 8'd3) ? 25 : 8 * m_rate + 1;
        rq = random_req();
        rq.kind = KIND_WIPE;
        queue_req(rq);
        repeat (steps)
        begin
            rq = random_req();
            rq.kind = KIND_SLOW;
            queue_req(rq);
            repeat ($urandom_range(1, 2))
            begin
                rq = random_req();
                rq.kind = KIND_SCAN;
                queue_req(rq);
            end
            if ($urandom_range(7) == 0)
            begin
                rq = random_req();
                rq.kind = KIND_DIGIT;
                queue_req(rq);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 6;
        rx_idle_pct = 74;

        // Directed: fades, pointer wrap, unscanned tube, blanking, odd styles and goals
        load_settings(1'b1, 1'b0, 8'h02, 8'd0, STYLE_SPARE);
        queue_fields(KIND_DIGIT, 3'd0, 4'd15, GOAL_ON, 8'h00);
        queue_fields(KIND_DIGIT, 3'd1, 4'd7, GOAL_ON, 8'h00);
        queue_fields(KIND_DIGIT, 3'd7, 4'd9, GOAL_ON, 8'h00);
        queue_fields(KIND_DIGIT, 3'd6, 4'd8, GOAL_ON, 8'h00);
        repeat (7)
            queue_fields(KIND_SCAN, 3'd0, 4'd0, GOAL_ON, 8'h00);
        queue_fields(KIND_EBLANK, 3'd0, 4'd0, GOAL_ON, 8'hFF);
        queue_fields(KIND_ALT, 3'd0, 4'd0, GOAL_ON, 8'h01);
        queue_fields(KIND_SCAN, 3'd7, 4'd15, GOAL_NONE, 8'hFF);
        queue_fields(KIND_WIPE, 3'd0, 4'd0, GOAL_NONE, 8'h00);
        queue_fields(KIND_SLOW, 3'd0, 4'd0, GOAL_ON, 8'h00);
        queue_fields(KIND_SCAN, 3'd0, 4'd0, GOAL_ON, 8'h00);
        queue_fields(KIND_WIPE, 3'd0, 4'd0, GOAL_ON, 8'h00);
        queue_fields(KIND_SLOW, 3'd0, 4'd0, GOAL_ON, 8'h00);
        queue_fields(KIND_SPARE_6, 3'd5, 4'd3, GOAL_OFF, 8'hA5);
        queue_fields(KIND_SPARE_7, 3'd2, 4'd12, GOAL_ALT, 8'h5A);
        queue_fields(KIND_SCAN, 3'd0, 4'd0, GOAL_ON, 8'h00);
        wait_idle();

        // Directed: everything blanked, mask writes and wipe starts ignored
        load_settings(1'b0, 1'b1, 8'hFF, 8'd255, STYLE_FROM_LOW);
        queue_fields(KIND_WIPE, 3'd0, 4'd0, GOAL_OFF, 8'h00);
        queue_fields(KIND_ALT, 3'd0, 4'd0, GOAL_ON, 8'hAA);
        queue_fields(KIND_EBLANK, 3'd0, 4'd0, GOAL_ON, 8'h55);
        queue_fields(KIND_SLOW, 3'd0, 4'd0, GOAL_ON, 8'h00);
        queue_fields(KIND_SCAN, 3'd0, 4'd0, GOAL_ON, 8'h00);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            // Idle pattern: sender light / receiver heavy, then swapped, then none
            if (ph < 3)
            begin
                tx_idle_pct = 6;
                rx_idle_pct = 74;
            end
            else if (ph < 6)
            begin
                tx_idle_pct = 74;
                rx_idle_pct = 6;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (ph)
                0: load_settings(1'b1, 1'b0, 8'($urandom_range(255)), 8'd1, STYLE_FROM_HIGH);
                1: load_settings(1'b1, 1'b0, 8'h00, 8'd2, STYLE_TOGGLE);
                2: load_settings(1'b0, 1'b0, 8'hFF, 8'd1, STYLE_FROM_LOW);
                3: load_settings(1'b1, 1'b1, 8'($urandom_range(255)), 8'd3, STYLE_TOGGLE);
                4: load_settings(1'b1, 1'b0, 8'($urandom_range(255)), 8'd255, STYLE_SPARE);
                5: load_settings(1'b1, 1'b0, 8'($urandom_range(255)),
                                 8'($urandom_range(1, 3)), 2'($urandom_range(3)));
                6: load_settings(1'b0, 1'b0, 8'($urandom_range(255)), 8'd1, STYLE_TOGGLE);
                default: load_settings(1'b1, 1'b0, 8'h00, 8'($urandom_range(1, 4)),
                                       2'($urandom_range(3)));
            endcase
            // Stall the result side while requests keep coming
            if (ph == 2)
                hold_asked++;
            queued_count = 0;
            while (queued_count < PHASE_REQUESTS)
            begin
                if ($urandom_range(9) == 0)
                    queue_wipe_sweep();
                else
                    queue_req(random_req());
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("nixie_scan_mux_crossfade_wipe_test: PASS");
        else
            $display("nixie_scan_mux_crossfade_wipe_test: FAIL");
        $finish;
    end

endmodule
